### design/obb_pkg.sv
// ----------------------------------------------------------------------------
// obb_pkg: shared types, widths and sine table for the oriented box overlap test
// Holds the fixed-point widths, the stream beat layout, the pipeline
// control struct and the quarter-wave Q1.14 sine table built at elaboration.
// ----------------------------------------------------------------------------
package obb_pkg;

  // Field widths of one box pair
  localparam int COORD_WIDTH      = 20;
  localparam int ANGLE_WIDTH      = 16;
  localparam int SINE_TABLE_DEPTH = 1024;
  localparam int HALF_WIDTH       = COORD_WIDTH - 1;

  // Sine table and trig arithmetic
  localparam int TRIG_WIDTH  = 16;
  localparam int FRAC_BITS   = 14;
  localparam int ONE_Q14     = 1 << FRAC_BITS;
  localparam int IDX_WIDTH   = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int PHASE_WIDTH = ANGLE_WIDTH - 2;
  localparam int SCALE_WIDTH = PHASE_WIDTH + IDX_WIDTH;

  // Datapath widths, sized so nothing wraps
  localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
  localparam int TPROD_WIDTH = 2 * TRIG_WIDTH;
  localparam int DOT_WIDTH   = TPROD_WIDTH + 1;
  localparam int MAG_WIDTH   = 2 * (TRIG_WIDTH - 1);
  localparam int CPROD_WIDTH = DIFF_WIDTH + TRIG_WIDTH;
  localparam int CDOT_WIDTH  = CPROD_WIDTH + 1;
  localparam int CMAG_WIDTH  = COORD_WIDTH + FRAC_BITS + 2;
  localparam int TERM_WIDTH  = HALF_WIDTH + MAG_WIDTH;
  localparam int SUM_WIDTH   = TERM_WIDTH + 1;
  localparam int NUM_AXES    = 4;

  // Input beat layout, first field in the lowest bits
  localparam int A_CX_LSB  = 0;
  localparam int A_CZ_LSB  = A_CX_LSB + COORD_WIDTH;
  localparam int A_HX_LSB  = A_CZ_LSB + COORD_WIDTH;
  localparam int A_HZ_LSB  = A_HX_LSB + HALF_WIDTH;
  localparam int A_YAW_LSB = A_HZ_LSB + HALF_WIDTH;
  localparam int B_CX_LSB  = A_YAW_LSB + ANGLE_WIDTH;
  localparam int B_CZ_LSB  = B_CX_LSB + COORD_WIDTH;
  localparam int B_HX_LSB  = B_CZ_LSB + COORD_WIDTH;
  localparam int B_HZ_LSB  = B_HX_LSB + HALF_WIDTH;
  localparam int B_YAW_LSB = B_HZ_LSB + HALF_WIDTH;
  localparam int IN_BITS   = B_YAW_LSB + ANGLE_WIDTH;

  localparam int S_TDATA_WIDTH = ((IN_BITS + 7) / 8) * 8;
  localparam int M_TDATA_WIDTH = 8;
  localparam int M_PAD_WIDTH   = M_TDATA_WIDTH - 1;

  // Table generation constants (Q30 Taylor series)
  localparam int                Q30_BITS     = 30;
  localparam int                ROUND_SHIFT  = Q30_BITS - FRAC_BITS;
  localparam longint unsigned   HALF_PI_Q30  = 64'd1686629713;
  localparam longint unsigned   SINE_DEPTH_L = 64'(SINE_TABLE_DEPTH);
  localparam longint unsigned   HALF_DEPTH_L = 64'(SINE_TABLE_DEPTH / 2);
  localparam longint unsigned   ROUND_HALF   = 64'd1 << (ROUND_SHIFT - 1);
  localparam longint            Q30_ONE      = 64'sd1 << Q30_BITS;

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quadrant_e;

  // Per-stage load enables, stage 7 is the output register
  typedef struct packed {
    logic en1;
    logic en2;
    logic en3;
    logic en4;
    logic en5;
    logic en6;
    logic en7;
  } pipe_en_t;

  typedef struct packed {
    logic [HALF_WIDTH-1:0] a_hx;
    logic [HALF_WIDTH-1:0] a_hz;
    logic [HALF_WIDTH-1:0] b_hx;
    logic [HALF_WIDTH-1:0] b_hz;
  } halves_t;

  // Axis dot products: own-axis norms, parallel and cross terms, centre distances
  typedef struct packed {
    logic [MAG_WIDTH-1:0]                 norm_a;
    logic [MAG_WIDTH-1:0]                 norm_b;
    logic [MAG_WIDTH-1:0]                 par;
    logic [MAG_WIDTH-1:0]                 crs;
    logic [NUM_AXES-1:0][CMAG_WIDTH-1:0]  ctr;
  } proj_t;

  typedef logic [TRIG_WIDTH-1:0] sine_table_t [SINE_TABLE_DEPTH+1];

  function automatic longint unsigned taylor_step(longint unsigned t, longint unsigned x);
    longint unsigned u;
    u = (t * x) >> Q30_BITS;
    return (u * x) >> Q30_BITS;
  endfunction

  function automatic sine_table_t build_sine_table();
    sine_table_t     tbl;
    longint unsigned x;
    longint unsigned t;
    longint          acc;
    for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
      x   = (HALF_PI_Q30 * 64'(i) + HALF_DEPTH_L) / SINE_DEPTH_L;
      acc = signed'(x);
      t   = taylor_step(x, x) / 6;
      acc = acc - signed'(t);
      t   = taylor_step(t, x) / 20;
      acc = acc + signed'(t);
      t   = taylor_step(t, x) / 42;
      acc = acc - signed'(t);
      t   = taylor_step(t, x) / 72;
      acc = acc + signed'(t);
      t   = taylor_step(t, x) / 110;
      acc = acc - signed'(t);
      t   = taylor_step(t, x) / 156;
      acc = acc + signed'(t);
      t   = taylor_step(t, x) / 210;
      acc = acc - signed'(t);
      if (acc < 0) acc = 0;
      if (acc > Q30_ONE) acc = Q30_ONE;
      tbl[i] = TRIG_WIDTH'((unsigned'(acc) + ROUND_HALF) >> ROUND_SHIFT);
    end
    tbl[SINE_TABLE_DEPTH] = TRIG_WIDTH'(ONE_Q14);
    return tbl;
  endfunction

  localparam sine_table_t SINE_TABLE = build_sine_table();

endpackage

### design/obb_overlap_sat_2d_top.sv
// ----------------------------------------------------------------------------
// obb_overlap_sat_2d_top: streaming overlap test for two oriented rectangles
// Separating axis test on four axes, one box pair per beat, fully pipelined.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Beat content                         Handshake
//  -------   ---  -----------------------------------  ----------------------
//  s_axis    in   box pair (centres, halves, yaws)     tvalid/tready, 24 bytes
//  m_axis    out  overlap flag in bit 0                tvalid/tready, 1 byte
//
//  Flow: one beat per cycle while m_axis is not stalled; each result passes
//  through the seven register stages in order (table read, quadrant
//  fold, trig/centre products, dot sums, extent products, axis sums, compare).
//  Reset clears every stage valid bit and the output valid; payload is not reset.
//  Stalls: each stage holds while the stage after it is full and not moving;
//  empty stages still fill, so bubbles close up and input keeps flowing.
// ----------------------------------------------------------------------------
module obb_overlap_sat_2d_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // tdata from bit 0 up: a_centre_x, a_centre_z, a_half_x, a_half_z, a_yaw,
  // b_centre_x, b_centre_z, b_half_x, b_half_z, b_yaw, zero padding
  input  logic [obb_pkg::S_TDATA_WIDTH-1:0]   s_axis_tdata_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // tdata from bit 0 up: overlap, zero padding
  output logic [obb_pkg::M_TDATA_WIDTH-1:0]   m_axis_tdata_o
);

  // Unpack the input beat
  logic signed [obb_pkg::COORD_WIDTH-1:0] a_cx, a_cz, b_cx, b_cz;
  logic [obb_pkg::ANGLE_WIDTH-1:0]        a_yaw, b_yaw;
  obb_pkg::halves_t                       halves;

  assign a_cx        = signed'(s_axis_tdata_i[obb_pkg::A_CX_LSB +: obb_pkg::COORD_WIDTH]);
  assign a_cz        = signed'(s_axis_tdata_i[obb_pkg::A_CZ_LSB +: obb_pkg::COORD_WIDTH]);
  assign halves.a_hx = s_axis_tdata_i[obb_pkg::A_HX_LSB +: obb_pkg::HALF_WIDTH];
  assign halves.a_hz = s_axis_tdata_i[obb_pkg::A_HZ_LSB +: obb_pkg::HALF_WIDTH];
  assign a_yaw       = s_axis_tdata_i[obb_pkg::A_YAW_LSB +: obb_pkg::ANGLE_WIDTH];
  assign b_cx        = signed'(s_axis_tdata_i[obb_pkg::B_CX_LSB +: obb_pkg::COORD_WIDTH]);
  assign b_cz        = signed'(s_axis_tdata_i[obb_pkg::B_CZ_LSB +: obb_pkg::COORD_WIDTH]);
  assign halves.b_hx = s_axis_tdata_i[obb_pkg::B_HX_LSB +: obb_pkg::HALF_WIDTH];
  assign halves.b_hz = s_axis_tdata_i[obb_pkg::B_HZ_LSB +: obb_pkg::HALF_WIDTH];
  assign b_yaw       = s_axis_tdata_i[obb_pkg::B_YAW_LSB +: obb_pkg::ANGLE_WIDTH];

  // Pipeline control: one valid bit per stage, stage 7 is the output register
  logic [5:0]        valid_q, valid_d;
  logic              out_valid_q, out_valid_d;
  obb_pkg::pipe_en_t stage_en;

  // A stage may load when it is empty or its content moves on this cycle
  always_comb begin
    stage_en.en7 = !out_valid_q || m_axis_tready_i;
    stage_en.en6 = !valid_q[5]  || stage_en.en7;
    stage_en.en5 = !valid_q[4]  || stage_en.en6;
    stage_en.en4 = !valid_q[3]  || stage_en.en5;
    stage_en.en3 = !valid_q[2]  || stage_en.en4;
    stage_en.en2 = !valid_q[1]  || stage_en.en3;
    stage_en.en1 = !valid_q[0]  || stage_en.en2;
  end

  assign s_axis_tready_o = stage_en.en1;

  // Advance valid bits with their stage enables; hold otherwise
  always_comb begin
    valid_d[0]  = stage_en.en1 ? s_axis_tvalid_i : valid_q[0];
    valid_d[1]  = stage_en.en2 ? valid_q[0] : valid_q[1];
    valid_d[2]  = stage_en.en3 ? valid_q[1] : valid_q[2];
    valid_d[3]  = stage_en.en4 ? valid_q[2] : valid_q[3];
    valid_d[4]  = stage_en.en5 ? valid_q[3] : valid_q[4];
    valid_d[5]  = stage_en.en6 ? valid_q[4] : valid_q[5];
    out_valid_d = stage_en.en7 ? valid_q[5] : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      valid_q     <= valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath
  logic signed [obb_pkg::TRIG_WIDTH-1:0] sin_a, cos_a, sin_b, cos_b;
  obb_pkg::proj_t                        proj;
  logic [obb_pkg::NUM_AXES-1:0]          sep;
  logic                                  overlap_q;

  obb_sincos u_sincos_a (
    .clk_i (clk_i),
    .en_i  (stage_en),
    .yaw_i (a_yaw),
    .sin_o (sin_a),
    .cos_o (cos_a)
  );

  obb_sincos u_sincos_b (
    .clk_i (clk_i),
    .en_i  (stage_en),
    .yaw_i (b_yaw),
    .sin_o (sin_b),
    .cos_o (cos_b)
  );

  obb_proj u_proj (
    .clk_i   (clk_i),
    .en_i    (stage_en),
    .a_cx_i  (a_cx),
    .a_cz_i  (a_cz),
    .b_cx_i  (b_cx),
    .b_cz_i  (b_cz),
    .sin_a_i (sin_a),
    .cos_a_i (cos_a),
    .sin_b_i (sin_b),
    .cos_b_i (cos_b),
    .proj_o  (proj)
  );

  obb_sep u_sep (
    .clk_i    (clk_i),
    .en_i     (stage_en),
    .halves_i (halves),
    .proj_i   (proj),
    .sep_o    (sep)
  );

  // Boxes overlap unless some axis separates them; touching counts as overlap
  always_ff @(posedge clk_i) begin
    if (stage_en.en7) begin
      overlap_q <= ~|sep;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {obb_pkg::M_PAD_WIDTH'(0), overlap_q};

  // An accepted beat always lands in stage 1
  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> valid_q[0])
    else $error("accepted beat did not enter stage 1");

  // A completely full pipe with a stalled output must refuse input
  a_full_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((&valid_q) && out_valid_q && !m_axis_tready_i) |-> !s_axis_tready_o)
    else $error("input taken while pipeline full and output stalled");

  // Stage 6 keeps its item while the output register cannot take it
  a_stage6_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q[5] && !stage_en.en7) |=> valid_q[5])
    else $error("stage 6 item dropped under stall");

  // Box axes never collapse to zero length
  a_axis_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[3] |-> (proj.norm_a != '0 && proj.norm_b != '0))
    else $error("zero-length box axis");

endmodule

### design/obb_sincos.sv
// ----------------------------------------------------------------------------
// obb_sincos: yaw phase to signed Q1.14 sine and cosine
// Stage 1 reads the quarter-wave table twice, stage 2 folds the quadrant.
// ----------------------------------------------------------------------------
module obb_sincos (
  input  logic                                  clk_i,
  input  obb_pkg::pipe_en_t                     en_i,
  input  logic [obb_pkg::ANGLE_WIDTH-1:0]       yaw_i,
  output logic signed [obb_pkg::TRIG_WIDTH-1:0] sin_o,
  output logic signed [obb_pkg::TRIG_WIDTH-1:0] cos_o
);

  logic [obb_pkg::SCALE_WIDTH-1:0] scaled;
  logic [obb_pkg::IDX_WIDTH-1:0]   idx_lo;
  logic [obb_pkg::IDX_WIDTH-1:0]   idx_hi;

  logic [obb_pkg::TRIG_WIDTH-1:0]  sv_q;
  logic [obb_pkg::TRIG_WIDTH-1:0]  cv_q;
  obb_pkg::quadrant_e              quad_q;

  logic signed [obb_pkg::TRIG_WIDTH-1:0] sin_d, cos_d, sin_q, cos_q;

  // Map the in-quadrant phase onto the table index range
  always_comb begin
    scaled = obb_pkg::SCALE_WIDTH'(yaw_i[obb_pkg::PHASE_WIDTH-1:0])
           * obb_pkg::SCALE_WIDTH'(obb_pkg::SINE_TABLE_DEPTH);
    idx_lo = obb_pkg::IDX_WIDTH'(scaled >> obb_pkg::PHASE_WIDTH);
    idx_hi = obb_pkg::IDX_WIDTH'(obb_pkg::SINE_TABLE_DEPTH) - idx_lo;
  end

  always_ff @(posedge clk_i) begin
    if (en_i.en1) begin
      sv_q   <= obb_pkg::SINE_TABLE[idx_lo];
      cv_q   <= obb_pkg::SINE_TABLE[idx_hi];
      quad_q <= obb_pkg::quadrant_e'(yaw_i[obb_pkg::ANGLE_WIDTH-1 -: 2]);
    end
  end

  always_comb begin
    case (quad_q)
      obb_pkg::QUAD_0: begin
        sin_d = signed'(sv_q);
        cos_d = signed'(cv_q);
      end
      obb_pkg::QUAD_1: begin
        sin_d = signed'(cv_q);
        cos_d = -signed'(sv_q);
      end
      obb_pkg::QUAD_2: begin
        sin_d = -signed'(sv_q);
        cos_d = -signed'(cv_q);
      end
      obb_pkg::QUAD_3: begin
        sin_d = -signed'(cv_q);
        cos_d = signed'(sv_q);
      end
      default: begin
        sin_d = signed'(sv_q);
        cos_d = signed'(cv_q);
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i.en2) begin
      sin_q <= sin_d;
      cos_q <= cos_d;
    end
  end

  assign sin_o = sin_q;
  assign cos_o = cos_q;

endmodule

### design/obb_proj.sv
// ----------------------------------------------------------------------------
// obb_proj: axis dot products and projected centre distances
// Stages 1-2 form and carry the centre offset, stage 3 multiplies,
// stage 4 sums and takes magnitudes.
// ----------------------------------------------------------------------------
module obb_proj (
  input  logic                                   clk_i,
  input  obb_pkg::pipe_en_t                      en_i,
  input  logic signed [obb_pkg::COORD_WIDTH-1:0] a_cx_i,
  input  logic signed [obb_pkg::COORD_WIDTH-1:0] a_cz_i,
  input  logic signed [obb_pkg::COORD_WIDTH-1:0] b_cx_i,
  input  logic signed [obb_pkg::COORD_WIDTH-1:0] b_cz_i,
  input  logic signed [obb_pkg::TRIG_WIDTH-1:0]  sin_a_i,
  input  logic signed [obb_pkg::TRIG_WIDTH-1:0]  cos_a_i,
  input  logic signed [obb_pkg::TRIG_WIDTH-1:0]  sin_b_i,
  input  logic signed [obb_pkg::TRIG_WIDTH-1:0]  cos_b_i,
  output obb_pkg::proj_t                         proj_o
);

  function automatic logic [obb_pkg::MAG_WIDTH-1:0] dot_mag(
    logic signed [obb_pkg::DOT_WIDTH-1:0] v
  );
    logic [obb_pkg::DOT_WIDTH-1:0] a;
    a = v[obb_pkg::DOT_WIDTH-1] ? unsigned'(-v) : unsigned'(v);
    return obb_pkg::MAG_WIDTH'(a);
  endfunction

  function automatic logic [obb_pkg::CMAG_WIDTH-1:0] ctr_mag(
    logic signed [obb_pkg::CDOT_WIDTH-1:0] v
  );
    logic [obb_pkg::CDOT_WIDTH-1:0] a;
    a = v[obb_pkg::CDOT_WIDTH-1] ? unsigned'(-v) : unsigned'(v);
    return obb_pkg::CMAG_WIDTH'(a);
  endfunction

  logic signed [obb_pkg::DIFF_WIDTH-1:0]  dx_q, dz_q, dx2_q, dz2_q;
  logic signed [obb_pkg::TPROD_WIDTH-1:0] caca_q, sasa_q, cbcb_q, sbsb_q;
  logic signed [obb_pkg::TPROD_WIDTH-1:0] cacb_q, sasb_q, casb_q, sacb_q;
  logic signed [obb_pkg::CPROD_WIDTH-1:0] dxca_q, dzsa_q, dxsa_q, dzca_q;
  logic signed [obb_pkg::CPROD_WIDTH-1:0] dxcb_q, dzsb_q, dxsb_q, dzcb_q;
  obb_pkg::proj_t                         proj_d, proj_q;

  always_ff @(posedge clk_i) begin
    if (en_i.en1) begin
      dx_q <= obb_pkg::DIFF_WIDTH'(b_cx_i) - obb_pkg::DIFF_WIDTH'(a_cx_i);
      dz_q <= obb_pkg::DIFF_WIDTH'(b_cz_i) - obb_pkg::DIFF_WIDTH'(a_cz_i);
    end
    if (en_i.en2) begin
      dx2_q <= dx_q;
      dz2_q <= dz_q;
    end
    if (en_i.en3) begin
      caca_q <= obb_pkg::TPROD_WIDTH'(cos_a_i) * obb_pkg::TPROD_WIDTH'(cos_a_i);
      sasa_q <= obb_pkg::TPROD_WIDTH'(sin_a_i) * obb_pkg::TPROD_WIDTH'(sin_a_i);
      cbcb_q <= obb_pkg::TPROD_WIDTH'(cos_b_i) * obb_pkg::TPROD_WIDTH'(cos_b_i);
      sbsb_q <= obb_pkg::TPROD_WIDTH'(sin_b_i) * obb_pkg::TPROD_WIDTH'(sin_b_i);
      cacb_q <= obb_pkg::TPROD_WIDTH'(cos_a_i) * obb_pkg::TPROD_WIDTH'(cos_b_i);
      sasb_q <= obb_pkg::TPROD_WIDTH'(sin_a_i) * obb_pkg::TPROD_WIDTH'(sin_b_i);
      casb_q <= obb_pkg::TPROD_WIDTH'(cos_a_i) * obb_pkg::TPROD_WIDTH'(sin_b_i);
      sacb_q <= obb_pkg::TPROD_WIDTH'(sin_a_i) * obb_pkg::TPROD_WIDTH'(cos_b_i);
      dxca_q <= obb_pkg::CPROD_WIDTH'(dx2_q) * obb_pkg::CPROD_WIDTH'(cos_a_i);
      dzsa_q <= obb_pkg::CPROD_WIDTH'(dz2_q) * obb_pkg::CPROD_WIDTH'(sin_a_i);
      dxsa_q <= obb_pkg::CPROD_WIDTH'(dx2_q) * obb_pkg::CPROD_WIDTH'(sin_a_i);
      dzca_q <= obb_pkg::CPROD_WIDTH'(dz2_q) * obb_pkg::CPROD_WIDTH'(cos_a_i);
      dxcb_q <= obb_pkg::CPROD_WIDTH'(dx2_q) * obb_pkg::CPROD_WIDTH'(cos_b_i);
      dzsb_q <= obb_pkg::CPROD_WIDTH'(dz2_q) * obb_pkg::CPROD_WIDTH'(sin_b_i);
      dxsb_q <= obb_pkg::CPROD_WIDTH'(dx2_q) * obb_pkg::CPROD_WIDTH'(sin_b_i);
      dzcb_q <= obb_pkg::CPROD_WIDTH'(dz2_q) * obb_pkg::CPROD_WIDTH'(cos_b_i);
    end
  end

  // Axis order: A0 of box A, A1 of box A, A0 of box B, A1 of box B
  always_comb begin
    proj_d.norm_a = dot_mag(obb_pkg::DOT_WIDTH'(caca_q) + obb_pkg::DOT_WIDTH'(sasa_q));
    proj_d.norm_b = dot_mag(obb_pkg::DOT_WIDTH'(cbcb_q) + obb_pkg::DOT_WIDTH'(sbsb_q));
    proj_d.par    = dot_mag(obb_pkg::DOT_WIDTH'(cacb_q) + obb_pkg::DOT_WIDTH'(sasb_q));
    proj_d.crs    = dot_mag(obb_pkg::DOT_WIDTH'(casb_q) - obb_pkg::DOT_WIDTH'(sacb_q));
    proj_d.ctr[0] = ctr_mag(obb_pkg::CDOT_WIDTH'(dxca_q) - obb_pkg::CDOT_WIDTH'(dzsa_q));
    proj_d.ctr[1] = ctr_mag(obb_pkg::CDOT_WIDTH'(dxsa_q) + obb_pkg::CDOT_WIDTH'(dzca_q));
    proj_d.ctr[2] = ctr_mag(obb_pkg::CDOT_WIDTH'(dxcb_q) - obb_pkg::CDOT_WIDTH'(dzsb_q));
    proj_d.ctr[3] = ctr_mag(obb_pkg::CDOT_WIDTH'(dxsb_q) + obb_pkg::CDOT_WIDTH'(dzcb_q));
  end

  always_ff @(posedge clk_i) begin
    if (en_i.en4) begin
      proj_q <= proj_d;
    end
  end

  assign proj_o = proj_q;

endmodule

### design/obb_sep.sv
// ----------------------------------------------------------------------------
// obb_sep: projected extents and per-axis separation flags
// Carries the half extents through stages 1-4, multiplies in stage 5,
// adds per axis in stage 6 and compares against the centre distance.
// ----------------------------------------------------------------------------
module obb_sep (
  input  logic                          clk_i,
  input  obb_pkg::pipe_en_t             en_i,
  input  obb_pkg::halves_t              halves_i,
  input  obb_pkg::proj_t                proj_i,
  output logic [obb_pkg::NUM_AXES-1:0]  sep_o
);

  obb_pkg::halves_t hd_q [4];

  logic [obb_pkg::TERM_WIDTH-1:0] ahx_n_q, ahz_n_q, bhx_n_q, bhz_n_q;
  logic [obb_pkg::TERM_WIDTH-1:0] ahx_p_q, ahz_p_q, ahx_c_q, ahz_c_q;
  logic [obb_pkg::TERM_WIDTH-1:0] bhx_p_q, bhz_p_q, bhx_c_q, bhz_c_q;
  logic [obb_pkg::SUM_WIDTH-1:0]  ctr5_q [obb_pkg::NUM_AXES];
  logic [obb_pkg::SUM_WIDTH-1:0]  ctr6_q [obb_pkg::NUM_AXES];
  logic [obb_pkg::SUM_WIDTH-1:0]  sum_q  [obb_pkg::NUM_AXES];

  always_ff @(posedge clk_i) begin
    if (en_i.en1) hd_q[0] <= halves_i;
    if (en_i.en2) hd_q[1] <= hd_q[0];
    if (en_i.en3) hd_q[2] <= hd_q[1];
    if (en_i.en4) hd_q[3] <= hd_q[2];
  end

  // Extent terms: own-axis norm, parallel and cross dot products
  always_ff @(posedge clk_i) begin
    if (en_i.en5) begin
      ahx_n_q <= obb_pkg::TERM_WIDTH'(hd_q[3].a_hx) * obb_pkg::TERM_WIDTH'(proj_i.norm_a);
      ahz_n_q <= obb_pkg::TERM_WIDTH'(hd_q[3].a_hz) * obb_pkg::TERM_WIDTH'(proj_i.norm_a);
      bhx_n_q <= obb_pkg::TERM_WIDTH'(hd_q[3].b_hx) * obb_pkg::TERM_WIDTH'(proj_i.norm_b);
      bhz_n_q <= obb_pkg::TERM_WIDTH'(hd_q[3].b_hz) * obb_pkg::TERM_WIDTH'(proj_i.norm_b);
      ahx_p_q <= obb_pkg::TERM_WIDTH'(hd_q[3].a_hx) * obb_pkg::TERM_WIDTH'(proj_i.par);
      ahz_p_q <= obb_pkg::TERM_WIDTH'(hd_q[3].a_hz) * obb_pkg::TERM_WIDTH'(proj_i.par);
      ahx_c_q <= obb_pkg::TERM_WIDTH'(hd_q[3].a_hx) * obb_pkg::TERM_WIDTH'(proj_i.crs);
      ahz_c_q <= obb_pkg::TERM_WIDTH'(hd_q[3].a_hz) * obb_pkg::TERM_WIDTH'(proj_i.crs);
      bhx_p_q <= obb_pkg::TERM_WIDTH'(hd_q[3].b_hx) * obb_pkg::TERM_WIDTH'(proj_i.par);
      bhz_p_q <= obb_pkg::TERM_WIDTH'(hd_q[3].b_hz) * obb_pkg::TERM_WIDTH'(proj_i.par);
      bhx_c_q <= obb_pkg::TERM_WIDTH'(hd_q[3].b_hx) * obb_pkg::TERM_WIDTH'(proj_i.crs);
      bhz_c_q <= obb_pkg::TERM_WIDTH'(hd_q[3].b_hz) * obb_pkg::TERM_WIDTH'(proj_i.crs);
      for (int i = 0; i < obb_pkg::NUM_AXES; i++) begin
        ctr5_q[i] <= obb_pkg::SUM_WIDTH'(proj_i.ctr[i]) << obb_pkg::FRAC_BITS;
      end
    end
  end

  // Own-box cross terms vanish exactly, so each axis sums three terms
  always_ff @(posedge clk_i) begin
    if (en_i.en6) begin
      sum_q[0] <= obb_pkg::SUM_WIDTH'(ahx_n_q) + obb_pkg::SUM_WIDTH'(bhx_p_q)
                + obb_pkg::SUM_WIDTH'(bhz_c_q);
      sum_q[1] <= obb_pkg::SUM_WIDTH'(ahz_n_q) + obb_pkg::SUM_WIDTH'(bhx_c_q)
                + obb_pkg::SUM_WIDTH'(bhz_p_q);
      sum_q[2] <= obb_pkg::SUM_WIDTH'(ahx_p_q) + obb_pkg::SUM_WIDTH'(ahz_c_q)
                + obb_pkg::SUM_WIDTH'(bhx_n_q);
      sum_q[3] <= obb_pkg::SUM_WIDTH'(ahx_c_q) + obb_pkg::SUM_WIDTH'(ahz_p_q)
                + obb_pkg::SUM_WIDTH'(bhz_n_q);
      ctr6_q   <= ctr5_q;
    end
  end

  always_comb begin
    for (int i = 0; i < obb_pkg::NUM_AXES; i++) begin
      sep_o[i] = ctr6_q[i] > sum_q[i];
    end
  end

endmodule
